@@ hw/rtl/bls_pkg.sv @@
// Shared types and constants for the Bresenham line stepper.
// Holds the input item, result pixel and internal command formats.
// No dependencies.
package bls_pkg;

	localparam int COORD_BITS = 12;
	localparam int SPAN_BITS  = COORD_BITS + 1;
	localparam int INC_BITS   = COORD_BITS + 2;
	localparam int ERR_BITS   = COORD_BITS + 4;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                           op;
		logic signed [COORD_BITS-1:0]  x_start;
		logic signed [COORD_BITS-1:0]  y_start;
		logic signed [COORD_BITS-1:0]  x_end;
		logic signed [COORD_BITS-1:0]  y_end;
	} item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0]  pixel_x;
		logic signed [COORD_BITS-1:0]  pixel_y;
		logic                          last_pixel;
	} pixel_t;

	// Classified command handed from the front end to the stepping engine.
	typedef struct packed {
		logic                          is_start;
		logic                          axes_swapped;
		logic signed [COORD_BITS-1:0]  major_pos;
		logic signed [COORD_BITS-1:0]  major_end;
		logic signed [COORD_BITS-1:0]  minor_pos;
		logic                          minor_step_down;
		logic [SPAN_BITS-1:0]          major_span;
		logic [INC_BITS-1:0]           error_increment;
	} cmd_t;

endpackage

@@ hw/rtl/bls_fifo.sv @@
// Small register-based queue used between the stages of the line stepper.
// Standalone; no package dependencies.
module bls_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_fire;
	logic             rd_fire;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_fire = wr_en && !full;
	assign rd_fire = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_fire, rd_fire})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ hw/rtl/bls_front.sv @@
// Front end of the line stepper: classifies items and sets up a new line.
// Depends on bls_pkg.
module bls_front (
	input  bls_pkg::item_t item,
	output bls_pkg::cmd_t  cmd
);

	localparam int C = bls_pkg::COORD_BITS;

	logic signed [C:0]   dx;
	logic signed [C:0]   dy;
	logic [C:0]          adx;
	logic [C:0]          ady;
	logic                steep;
	logic signed [C:0]   dmaj;
	logic signed [C:0]   dmin;
	logic                reorder;
	logic signed [C-1:0] sx, sy, ex, ey;

	always_comb begin
		dx  = {item.x_start[C-1], item.x_start} - {item.x_end[C-1], item.x_end};
		dy  = {item.y_start[C-1], item.y_start} - {item.y_end[C-1], item.y_end};
		adx = dx[C] ? (~dx + 1'b1) : dx;
		ady = dy[C] ? (~dy + 1'b1) : dy;

		// Steep lines use y as the major axis; equal spans stay on x.
		steep = adx < ady;
		dmaj  = steep ? dy : dx;
		dmin  = steep ? dx : dy;

		// Swap endpoints when the start lies beyond the end on the major axis.
		reorder = !dmaj[C] && (dmaj != '0);
		sx = reorder ? item.x_end   : item.x_start;
		sy = reorder ? item.y_end   : item.y_start;
		ex = reorder ? item.x_start : item.x_end;
		ey = reorder ? item.y_start : item.y_end;

		cmd.is_start        = (item.op == bls_pkg::OP_START);
		cmd.axes_swapped    = steep;
		cmd.major_pos       = steep ? sy : sx;
		cmd.major_end       = steep ? ey : ex;
		cmd.minor_pos       = steep ? sx : sy;
		cmd.minor_step_down = reorder ? dmin[C] : (!dmin[C] && (dmin != '0));
		cmd.major_span      = steep ? ady : adx;
		cmd.error_increment = {(steep ? adx : ady), 1'b0};
	end

endmodule

@@ hw/rtl/bls_back.sv @@
// Stepping engine of the line stepper: holds the line state and emits pixels.
// Depends on bls_pkg.
module bls_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bls_pkg::cmd_t   cmd,
	input  logic            cmd_valid,
	output logic            cmd_pop,
	input  logic            out_full,
	output logic            pixel_wr,
	output bls_pkg::pixel_t pixel
);

	localparam int C  = bls_pkg::COORD_BITS;
	localparam int SB = bls_pkg::SPAN_BITS;
	localparam int IB = bls_pkg::INC_BITS;
	localparam int EB = bls_pkg::ERR_BITS;

	logic                line_active_q;
	logic                axes_swapped_q;
	logic signed [C-1:0] major_pos_q;
	logic signed [C-1:0] major_end_q;
	logic signed [C-1:0] minor_pos_q;
	logic                minor_step_down_q;
	logic [SB-1:0]       major_span_q;
	logic [IB-1:0]       error_increment_q;
	logic signed [EB-1:0] error_term_q;

	logic signed [EB-1:0] err_add;
	logic signed [EB-1:0] err_sub;
	logic                 minor_move;
	logic                 last;
	logic                 load;

	always_comb begin
		err_add    = error_term_q + {2'b00, error_increment_q};
		err_sub    = error_term_q + {2'b00, error_increment_q} - {2'b00, major_span_q, 1'b0};
		minor_move = err_add > $signed({3'b000, major_span_q});
		last       = (major_pos_q == major_end_q);

		load     = cmd_valid && cmd.is_start;
		pixel_wr = cmd_valid && !cmd.is_start && line_active_q && !out_full;
		cmd_pop  = cmd_valid && (cmd.is_start || !line_active_q || !out_full);

		pixel.pixel_x    = axes_swapped_q ? minor_pos_q : major_pos_q;
		pixel.pixel_y    = axes_swapped_q ? major_pos_q : minor_pos_q;
		pixel.last_pixel = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
		end else if (load) begin
			line_active_q <= 1'b1;
		end else if (pixel_wr && last) begin
			line_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			axes_swapped_q    <= cmd.axes_swapped;
			major_pos_q       <= cmd.major_pos;
			major_end_q       <= cmd.major_end;
			minor_pos_q       <= cmd.minor_pos;
			minor_step_down_q <= cmd.minor_step_down;
			major_span_q      <= cmd.major_span;
			error_increment_q <= cmd.error_increment;
			error_term_q      <= '0;
		end else if (pixel_wr && !last) begin
			major_pos_q  <= major_pos_q + 1'b1;
			error_term_q <= minor_move ? err_sub : err_add;
			if (minor_move) begin
				minor_pos_q <= minor_pos_q + {{(C-1){minor_step_down_q}}, 1'b1};
			end
		end
	end

endmodule

@@ hw/rtl/bresenham_line_stepper_core.sv @@
// Top level of the Bresenham line stepper.
// Depends on bls_pkg, bls_front, bls_fifo and bls_back.
//
// Channel   Direction  Handshake              Payload
// item      in         push / full            bls_pkg::item_t  (op, endpoints)
// pixel     out        pop / empty            bls_pkg::pixel_t (x, y, last flag)
//
// The block accepts one item every clock cycle while full is low and emits at most one
// pixel per cycle. A step item's command passes through the command queue, and its
// pixel is written to the result queue and can be taken from the result ports there.
// Reset clears the queues and drops any active line; coordinate state is not cleared.
// When the result side stalls, the result queue fills first, then the command queue,
// and full rises only once both are holding back work.

module bresenham_line_stepper_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  bls_pkg::item_t  item,
	output logic            empty,
	input  logic            pop,
	output bls_pkg::pixel_t pixel
);

	localparam int CMD_W = $bits(bls_pkg::cmd_t);
	localparam int PIX_W = $bits(bls_pkg::pixel_t);

	bls_pkg::cmd_t   front_cmd;
	bls_pkg::cmd_t   head_cmd;
	logic [CMD_W-1:0] head_bits;
	logic            cmd_empty;
	logic            cmd_pop;
	bls_pkg::pixel_t back_pixel;
	logic            pixel_wr;
	logic            out_full;
	logic [PIX_W-1:0] out_bits;

	// The front end works out the line setup for a start item as it is accepted.
	bls_front u_front (
		.item (item),
		.cmd  (front_cmd)
	);

	// The command queue decouples acceptance from stepping, so a stalled
	// result side does not stop the input side until this queue fills.
	bls_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (head_bits),
		.empty   (cmd_empty)
	);

	assign head_cmd = bls_pkg::cmd_t'(head_bits);

	// The engine takes one command per cycle unless a step waits on a full result queue.
	// Start commands and steps with no active line are retired without producing a result.
	bls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.pixel_wr  (pixel_wr),
		.pixel     (back_pixel)
	);

	// The result queue holds finished pixels until the consumer takes them.
	bls_fifo #(
		.WIDTH (PIX_W),
		.DEPTH (2)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pixel_wr),
		.wr_data (back_pixel),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_bits),
		.empty   (empty)
	);

	assign pixel = bls_pkg::pixel_t'(out_bits);

endmodule

@@ hw/rtl/bls_checker.sv @@
// Port-level checks for the Bresenham line stepper, bound to the top level.
// Depends on bls_pkg and bresenham_line_stepper_core.
module bls_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            push,
	input logic            full,
	input logic            empty,
	input logic            pop,
	input bls_pkg::pixel_t pixel
);

	// A waiting pixel stays put until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pixel)))
		else $error("result changed or vanished while stalled");

	// The input side can only fill up because of a push.
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// Commands back up only behind results that are waiting to be taken.
	a_full_implies_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input full while no result is waiting");

	// After reset nothing is waiting on the result side.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result waiting right after reset");

endmodule

bind bresenham_line_stepper_core bls_checker u_bls_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.pixel  (pixel)
);

@@ verif/bresenham_line_stepper_core_test.sv @@
// Self-checking testbench for bresenham_line_stepper_core: directed lines, then random ones.
// A scoreboard class predicts every pixel and checks the block's results in order.
// Depends on bls_pkg and the bresenham_line_stepper_core RTL.
module bresenham_line_stepper_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [bls_pkg::COORD_BITS-1:0] coord_t;

	localparam int COORD_MIN    = -(1 << (bls_pkg::COORD_BITS - 1));
	localparam int COORD_MAX    = (1 << (bls_pkg::COORD_BITS - 1)) - 1;
	localparam coord_t SCREEN_MIN = coord_t'(COORD_MIN);
	localparam coord_t SCREEN_MAX = coord_t'(COORD_MAX);
	localparam int RANDOM_ITEMS = 2000;
	// A pixel reaches the result ports through the command and result queues; this wait
	// gives stray results time to show up after the last owed pixel.
	localparam int DRAIN_CYCLES = 12;
	// Slowest run: about 2100 counted items plus ignored ones, each with random sender gaps
	// and a pixel that may wait out a receiver idling 75 percent of the time.
	// This limit leaves ample headroom over that run.
	localparam int CYCLE_LIMIT  = 300000;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	bls_pkg::item_t   item;
	logic             empty;
	logic             pop;
	bls_pkg::pixel_t  pixel;

	// Percent chance per cycle that each side holds off.
	int      send_idle_pct = 19;
	int      recv_idle_pct = 75;
	// Items that started a line or produced a pixel; ignored steps do not count.
	int      drawn_items;
	int      cycle_count;

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	// Tracks the line being drawn and holds the pixels the block still owes us.
	class pixel_scoreboard;
		bit      line_active;
		bit      axes_swapped;
		bit      minor_step_down;
		int      major_pos;
		int      major_end;
		int      minor_pos;
		int      major_span;
		int      error_increment;
		int      error_term;
		bls_pkg::pixel_t  expected_pixels[$];
		int      mismatch_count;

		function int pending();
			return expected_pixels.size();
		endfunction

		// Called for every accepted item transfer. Returns 1 when the item started a
		// line or produced a pixel, so the caller can tell useful items from ignored ones.
		function bit note_item(bls_pkg::item_t it);
			int      a0;
			int      b0;
			int      a1;
			int      b1;
			int      t;
			bit      steep;
			bit      last;
			bls_pkg::pixel_t  px;
			if (it.op == bls_pkg::OP_START) begin
				a0 = int'(it.x_start);
				b0 = int'(it.y_start);
				a1 = int'(it.x_end);
				b1 = int'(it.y_end);
				// Equal spans are not steep, so x stays the major axis.
				steep = magnitude(a0 - a1) < magnitude(b0 - b1);
				if (steep) begin
					t = a0; a0 = b0; b0 = t;
					t = a1; a1 = b1; b1 = t;
				end
				if (a0 > a1) begin
					t = a0; a0 = a1; a1 = t;
					t = b0; b0 = b1; b1 = t;
				end
				axes_swapped    = steep;
				major_pos       = a0;
				major_end       = a1;
				minor_pos       = b0;
				minor_step_down = b1 < b0;
				major_span      = a1 - a0;
				error_increment = 2 * magnitude(b1 - b0);
				error_term      = 0;
				line_active     = 1'b1;
				return 1'b1;
			end
			if (!line_active)
				return 1'b0;
			last          = (major_pos == major_end);
			px.pixel_x    = axes_swapped ? minor_pos[bls_pkg::COORD_BITS-1:0]
				: major_pos[bls_pkg::COORD_BITS-1:0];
			px.pixel_y    = axes_swapped ? major_pos[bls_pkg::COORD_BITS-1:0]
				: minor_pos[bls_pkg::COORD_BITS-1:0];
			px.last_pixel = last;
			expected_pixels = {expected_pixels, px};
			if (last) begin
				line_active = 1'b0;
			end else begin
				major_pos  += 1;
				error_term += error_increment;
				if (error_term > major_span) begin
					minor_pos  += minor_step_down ? -1 : 1;
					error_term -= 2 * major_span;
				end
			end
			return 1'b1;
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatch_count++;
		endtask

		// Called for every accepted pixel transfer.
		task check_pixel(bls_pkg::pixel_t got);
			bls_pkg::pixel_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
					got.pixel_x, got.pixel_y, got.last_pixel));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_x !== want.pixel_x)
				report($sformatf("pixel_x got %0d expected %0d", got.pixel_x, want.pixel_x));
			if (got.pixel_y !== want.pixel_y)
				report($sformatf("pixel_y got %0d expected %0d", got.pixel_y, want.pixel_y));
			if (got.last_pixel !== want.last_pixel)
				report($sformatf("last_pixel got %0b expected %0b at x=%0d y=%0d",
					got.last_pixel, want.last_pixel, want.pixel_x, want.pixel_y));
		endtask
	endclass

	pixel_scoreboard sb = new;

	bresenham_line_stepper_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.pixel  (pixel)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Fills every field with random bits, so the fields that an item ignores still toggle.
	function automatic bls_pkg::item_t rand_item(bls_pkg::op_t op);
		logic [63:0]     bits;
		bls_pkg::item_t  it;
		bits  = {$urandom, $urandom};
		it    = bits[$bits(bls_pkg::item_t)-1:0];
		it.op = op;
		return it;
	endfunction

	// A coordinate anywhere on the screen, with the two extremes drawn more often.
	function automatic coord_t rand_coord();
		int pick;
		pick = $urandom_range(15);
		if (pick == 0)
			return SCREEN_MIN;
		if (pick == 1)
			return SCREEN_MAX;
		return coord_t'($urandom);
	endfunction

	// A coordinate within reach of base, clamped to the screen so that short lines stay short.
	function automatic coord_t offset_coord(coord_t base, int reach);
		int v;
		v = int'(base) + int'($urandom_range(2 * reach)) - reach;
		if (v < COORD_MIN)
			v = COORD_MIN;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[bls_pkg::COORD_BITS-1:0];
	endfunction

	// Number of pixels a line between the two endpoints has.
	function automatic int line_length(int x0, int y0, int x1, int y1);
		int dx;
		int dy;
		dx = magnitude(x1 - x0);
		dy = magnitude(y1 - y0);
		return ((dx > dy) ? dx : dy) + 1;
	endfunction

	// Offers one item and waits for its transfer. push is written once per time step:
	// it drops only during a random gap and otherwise stays high from one item to the next.
	task automatic send_item(bls_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		// Right after the edge, full still holds the value the edge sampled.
		do
			@(posedge clk);
		while (full);
		drawn_items += sb.note_item(it);
	endtask

	task automatic send_start(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		bls_pkg::item_t it;
		it         = rand_item(bls_pkg::OP_START);
		it.x_start = x0;
		it.y_start = y0;
		it.x_end   = x1;
		it.y_end   = y1;
		send_item(it);
	endtask

	task automatic send_steps(int count);
		repeat (count)
			send_item(rand_item(bls_pkg::OP_STEP));
	endtask

	// Result side: takes a pixel whenever pop was high and empty was low at the edge,
	// then decides at random whether to pop during the next cycle. pop stays low in reset.
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				sb.check_pixel(pixel);
			pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: ends the run with an error once it reaches the cycle limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[bresenham_line_stepper_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		int     pick;
		int     reach;
		int     steps;

		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A step before any start must produce nothing.
		send_steps(1);
		// Equal endpoints at both screen corners give one final pixel each; the step after
		// the final pixel finds no line and is ignored.
		send_start(SCREEN_MIN, SCREEN_MIN, SCREEN_MIN, SCREEN_MIN);
		send_steps(2);
		send_start(SCREEN_MAX, SCREEN_MAX, SCREEN_MAX, SCREEN_MAX);
		send_steps(1);
		// Shallow line drawn right to left, so the endpoints swap and the minor axis falls.
		send_start(coord_t'(3), coord_t'(-2), coord_t'(-1), coord_t'(1));
		send_steps(5);
		// Equal spans keep x as the major axis.
		send_start(coord_t'(0), coord_t'(0), coord_t'(-3), coord_t'(3));
		send_steps(4);
		// Steep line along the bottom edge: y becomes the major axis.
		send_start(coord_t'(5), SCREEN_MIN, coord_t'(7), coord_t'(COORD_MIN + 4));
		send_steps(5);
		// Full-screen diagonal with the widest spans, abandoned by the next start.
		send_start(SCREEN_MIN, SCREEN_MAX, SCREEN_MAX, SCREEN_MIN);
		send_steps(2);

		// Random part. It runs in three phases of item pacing: a slow receiver, then a slow
		// sender, then both sides at full rate. Most sequences are complete short lines; the
		// rest abandon a line midway, overrun its end, or are random noise items.
		drawn_items = 0;
		while (drawn_items < RANDOM_ITEMS) begin
			case ((drawn_items * 3) / RANDOM_ITEMS)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			pick = $urandom_range(99);
			if (pick < 84) begin
				reach = ($urandom_range(9) == 0) ? 40 : 6;
				x0    = rand_coord();
				y0    = rand_coord();
				x1    = offset_coord(x0, reach);
				y1    = offset_coord(y0, reach);
				send_start(x0, y0, x1, y1);
				steps = line_length(int'(x0), int'(y0), int'(x1), int'(y1));
				if ($urandom_range(9) == 0)
					steps = $urandom_range(steps - 1);
				else if ($urandom_range(7) == 0)
					steps++;
				send_steps(steps);
			end else if (pick < 92) begin
				// Long line anywhere on screen; usually cut short by the next start.
				x0 = rand_coord();
				y0 = rand_coord();
				x1 = rand_coord();
				y1 = rand_coord();
				send_start(x0, y0, x1, y1);
				steps = line_length(int'(x0), int'(y0), int'(x1), int'(y1));
				if (steps > 24)
					steps = $urandom_range(1, 24);
				send_steps(steps);
			end else begin
				repeat ($urandom_range(1, 3))
					send_item(rand_item(bls_pkg::op_t'($urandom_range(1))));
			end
		end
		push <= 1'b0;

		// Let every owed pixel arrive, then give stray results a chance to show up.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("[bresenham_line_stepper_core] OK");
		else
			$display("[bresenham_line_stepper_core] ERROR");
		$finish;
	end

endmodule
